// ===== hdl/e2q_pkg.sv =====
package e2q_pkg;

	localparam int ANGLE_W             = 16;
	localparam int COMP_W              = 16;
	localparam int ANGLE_FRAC_BITS     = 12;
	localparam int COMPONENT_FRAC_BITS = 14;
	localparam int WORK_FRAC           = 30;

	localparam int HALF_SHIFT = WORK_FRAC - 1 - ANGLE_FRAC_BITS;
	localparam int X_W        = ANGLE_W + HALF_SHIFT;

	localparam longint HALF_PI_W    = 64'h6487ED51;
	localparam longint QUARTER_PI_W = 64'h3243F6A9;

	localparam int K_MAX = int'(((longint'(1) << (ANGLE_W - 1 + HALF_SHIFT)) + QUARTER_PI_W)
		/ HALF_PI_W);
	localparam int K_W   = ($clog2(K_MAX + 1) < 2) ? 2 : $clog2(K_MAX + 1);

	localparam int R_W = WORK_FRAC;
	localparam int T_W = WORK_FRAC + 1;
	localparam int V_W = WORK_FRAC + 2;

	localparam int N_CELLS  = 6;
	localparam int RED_LAT  = 5;
	localparam int CELL_LAT = 2;
	localparam int FIN_LAT  = 2;
	localparam int CMB_LAT  = 9;
	localparam int SC_LAT   = RED_LAT + N_CELLS * CELL_LAT + FIN_LAT;
	localparam int TOTAL_LAT = SC_LAT + CMB_LAT;

	localparam int OUT_SHIFT = WORK_FRAC - COMPONENT_FRAC_BITS;

	localparam longint COMP_LIM     = longint'(1) << COMPONENT_FRAC_BITS;
	localparam longint COMP_POS_MAX = (COMP_LIM < (longint'(1) << (COMP_W - 1)) - 1) ?
		COMP_LIM : (longint'(1) << (COMP_W - 1)) - 1;
	localparam longint COMP_NEG_MAX = (COMP_LIM < (longint'(1) << (COMP_W - 1))) ?
		COMP_LIM : (longint'(1) << (COMP_W - 1));

	localparam int N_AXES   = 3;
	localparam int AX_ROLL  = 0;
	localparam int AX_PITCH = 1;
	localparam int AX_YAW   = 2;

	typedef struct packed {
		logic           hneg;
		logic           rneg;
		logic [K_W-1:0] quad;
	} ang_ctl_t;

	function automatic logic [X_W-1:0] k_threshold(input int j);
		return X_W'(longint'(j) * HALF_PI_W - QUARTER_PI_W);
	endfunction

endpackage

// ===== hdl/e2q_reduce.sv =====
module e2q_reduce import e2q_pkg::*; (
	input  logic                      clk,
	input  logic signed [ANGLE_W-1:0] angle,
	output logic        [R_W-1:0]     r_mag,
	output logic        [R_W-1:0]     r_sq,
	output ang_ctl_t                  ctl
);

	logic [ANGLE_W-1:0] ax_s1;
	logic               hneg_s1;
	logic [X_W-1:0]     x_c;
	logic [K_W-1:0]     k_c;
	logic [X_W-1:0]     x_s2;
	logic [K_W-1:0]     k_s2;
	logic               hneg_s2;
	logic [X_W:0]       kh_c;
	logic signed [X_W:0] r_c;
	logic signed [X_W:0] r_s3;
	logic [K_W-1:0]     k_s3;
	logic               hneg_s3;
	logic [R_W-1:0]     ra_s4;
	ang_ctl_t           ctl_s4;
	logic [2*R_W-1:0]   sq_c;
	logic [R_W-1:0]     ra_s5;
	logic [R_W-1:0]     r2_s5;
	ang_ctl_t           ctl_s5;

	// quadrant count from the fixed thresholds
	always_comb begin
		x_c = X_W'(ax_s1) << HALF_SHIFT;
		k_c = '0;
		for (int j = 1; j <= K_MAX; j++) begin
			if (x_c >= k_threshold(j)) begin
				k_c = k_c + K_W'(1);
			end
		end
	end

	assign kh_c = (X_W + 1)'(k_s2) * (X_W + 1)'(HALF_PI_W);
	assign r_c  = $signed({1'b0, x_s2}) - $signed(kh_c);
	assign sq_c = (2 * R_W)'(ra_s4) * (2 * R_W)'(ra_s4);

	always_ff @(posedge clk) begin
		ax_s1   <= angle[ANGLE_W-1] ? ANGLE_W'(-angle) : ANGLE_W'(angle);
		hneg_s1 <= angle[ANGLE_W-1];

		x_s2    <= x_c;
		k_s2    <= k_c;
		hneg_s2 <= hneg_s1;

		r_s3    <= r_c;
		k_s3    <= k_s2;
		hneg_s3 <= hneg_s2;

		ra_s4       <= r_s3[X_W] ? R_W'(-r_s3) : R_W'(r_s3);
		ctl_s4.hneg <= hneg_s3;
		ctl_s4.rneg <= r_s3[X_W];
		ctl_s4.quad <= k_s3;

		ra_s5  <= ra_s4;
		r2_s5  <= sq_c[WORK_FRAC +: R_W];
		ctl_s5 <= ctl_s4;
	end

	assign r_mag = ra_s5;
	assign r_sq  = r2_s5;
	assign ctl   = ctl_s5;

endmodule

// ===== hdl/e2q_cell.sv =====
module e2q_cell import e2q_pkg::*; #(
	parameter int IDX = 1
) (
	input  logic                  clk,
	input  logic        [T_W-1:0] ts_i,
	input  logic        [T_W-1:0] tc_i,
	input  logic signed [V_W-1:0] ss_i,
	input  logic signed [V_W-1:0] sc_i,
	input  logic        [R_W-1:0] r2_i,
	input  ang_ctl_t              ctl_i,
	output logic        [T_W-1:0] ts_o,
	output logic        [T_W-1:0] tc_o,
	output logic signed [V_W-1:0] ss_o,
	output logic signed [V_W-1:0] sc_o,
	output logic        [R_W-1:0] r2_o,
	output ang_ctl_t              ctl_o
);

	localparam int M_W    = WORK_FRAC + 2;
	localparam int DIV_S  = (2 * IDX) * (2 * IDX + 1);
	localparam int DIV_C  = (2 * IDX - 1) * (2 * IDX);
	localparam int SH_S   = WORK_FRAC + $clog2(DIV_S);
	localparam int SH_C   = WORK_FRAC + $clog2(DIV_C);
	localparam longint unsigned MAG_S_L = ((64'd1 << SH_S) + DIV_S - 1) / DIV_S;
	localparam longint unsigned MAG_C_L = ((64'd1 << SH_C) + DIV_C - 1) / DIV_C;
	localparam logic [M_W-1:0] MAG_S = M_W'(MAG_S_L);
	localparam logic [M_W-1:0] MAG_C = M_W'(MAG_C_L);
	localparam bit ADD_TERM = (IDX % 2) == 1;

	logic [T_W+R_W-1:0] tps_c;
	logic [T_W+R_W-1:0] tpc_c;
	logic [R_W-1:0]     ps_s1;
	logic [R_W-1:0]     pc_s1;
	logic signed [V_W-1:0] ss_s1;
	logic signed [V_W-1:0] sc_s1;
	logic [R_W-1:0]     r2_s1;
	ang_ctl_t           ctl_s1;
	logic [R_W+M_W-1:0] qs_c;
	logic [R_W+M_W-1:0] qc_c;
	logic [T_W-1:0]     ts_s2;
	logic [T_W-1:0]     tc_s2;
	logic signed [V_W-1:0] ss_s2;
	logic signed [V_W-1:0] sc_s2;
	logic [R_W-1:0]     r2_s2;
	ang_ctl_t           ctl_s2;

	assign tps_c = (T_W + R_W)'(ts_i) * (T_W + R_W)'(r2_i);
	assign tpc_c = (T_W + R_W)'(tc_i) * (T_W + R_W)'(r2_i);

	// exact floor division by a constant through its rounded-up reciprocal
	assign qs_c = (R_W + M_W)'(ps_s1) * (R_W + M_W)'(MAG_S);
	assign qc_c = (R_W + M_W)'(pc_s1) * (R_W + M_W)'(MAG_C);

	always_ff @(posedge clk) begin
		ps_s1  <= tps_c[WORK_FRAC +: R_W];
		pc_s1  <= tpc_c[WORK_FRAC +: R_W];
		ss_s1  <= ADD_TERM ? ss_i + $signed(V_W'(ts_i)) : ss_i - $signed(V_W'(ts_i));
		sc_s1  <= ADD_TERM ? sc_i + $signed(V_W'(tc_i)) : sc_i - $signed(V_W'(tc_i));
		r2_s1  <= r2_i;
		ctl_s1 <= ctl_i;

		ts_s2  <= T_W'(qs_c >> SH_S);
		tc_s2  <= T_W'(qc_c >> SH_C);
		ss_s2  <= ss_s1;
		sc_s2  <= sc_s1;
		r2_s2  <= r2_s1;
		ctl_s2 <= ctl_s1;
	end

	assign ts_o  = ts_s2;
	assign tc_o  = tc_s2;
	assign ss_o  = ss_s2;
	assign sc_o  = sc_s2;
	assign r2_o  = r2_s2;
	assign ctl_o = ctl_s2;

endmodule

// ===== hdl/e2q_sincos.sv =====
module e2q_sincos import e2q_pkg::*; (
	input  logic                      clk,
	input  logic signed [ANGLE_W-1:0] angle,
	output logic signed [V_W-1:0]     sin_v,
	output logic signed [V_W-1:0]     cos_v
);

	localparam logic [T_W-1:0] T_ONE    = T_W'(1) << WORK_FRAC;
	localparam bit             LAST_ADD = ((N_CELLS + 1) % 2) == 1;

	logic [R_W-1:0] r_mag;
	logic [R_W-1:0] r_sq;
	ang_ctl_t       r_ctl;

	logic        [T_W-1:0] ts_c [N_CELLS+1];
	logic        [T_W-1:0] tc_c [N_CELLS+1];
	logic signed [V_W-1:0] ss_c [N_CELLS+1];
	logic signed [V_W-1:0] sc_c [N_CELLS+1];
	logic        [R_W-1:0] r2_c [N_CELLS+1];
	ang_ctl_t              ctl_c [N_CELLS+1];

	logic signed [V_W-1:0] sr_s1;
	logic signed [V_W-1:0] cr_s1;
	ang_ctl_t              ctl_s1;
	logic signed [V_W-1:0] base_s;
	logic signed [V_W-1:0] base_c;
	logic                  neg_s;
	logic                  neg_c;
	logic signed [V_W-1:0] sin_s2;
	logic signed [V_W-1:0] cos_s2;

	e2q_reduce u_reduce (
		.clk   (clk),
		.angle (angle),
		.r_mag (r_mag),
		.r_sq  (r_sq),
		.ctl   (r_ctl)
	);

	assign ts_c[0]  = T_W'(r_mag);
	assign tc_c[0]  = T_ONE;
	assign ss_c[0]  = '0;
	assign sc_c[0]  = '0;
	assign r2_c[0]  = r_sq;
	assign ctl_c[0] = r_ctl;

	genvar g;
	for (g = 0; g < N_CELLS; g++) begin : g_cell
		e2q_cell #(.IDX(g + 1)) u_cell (
			.clk   (clk),
			.ts_i  (ts_c[g]),
			.tc_i  (tc_c[g]),
			.ss_i  (ss_c[g]),
			.sc_i  (sc_c[g]),
			.r2_i  (r2_c[g]),
			.ctl_i (ctl_c[g]),
			.ts_o  (ts_c[g+1]),
			.tc_o  (tc_c[g+1]),
			.ss_o  (ss_c[g+1]),
			.sc_o  (sc_c[g+1]),
			.r2_o  (r2_c[g+1]),
			.ctl_o (ctl_c[g+1])
		);
	end

	// quadrant mapping with sign of the reduced and of the half angle
	always_comb begin
		base_s = ctl_s1.quad[0] ? cr_s1 : sr_s1;
		base_c = ctl_s1.quad[0] ? sr_s1 : cr_s1;
		neg_s  = ctl_s1.quad[1] ^ ctl_s1.hneg ^ (~ctl_s1.quad[0] & ctl_s1.rneg);
		neg_c  = ctl_s1.quad[0] ^ ctl_s1.quad[1] ^ (ctl_s1.quad[0] & ctl_s1.rneg);
	end

	always_ff @(posedge clk) begin
		sr_s1  <= LAST_ADD ? ss_c[N_CELLS] + $signed(V_W'(ts_c[N_CELLS])) :
			ss_c[N_CELLS] - $signed(V_W'(ts_c[N_CELLS]));
		cr_s1  <= LAST_ADD ? sc_c[N_CELLS] + $signed(V_W'(tc_c[N_CELLS])) :
			sc_c[N_CELLS] - $signed(V_W'(tc_c[N_CELLS]));
		ctl_s1 <= ctl_c[N_CELLS];

		sin_s2 <= neg_s ? -base_s : base_s;
		cos_s2 <= neg_c ? -base_c : base_c;
	end

	assign sin_v = sin_s2;
	assign cos_v = cos_s2;

endmodule

// ===== hdl/e2q_combine.sv =====
module e2q_combine import e2q_pkg::*; (
	input  logic                     clk,
	input  logic signed [V_W-1:0]    sin_v [N_AXES],
	input  logic signed [V_W-1:0]    cos_v [N_AXES],
	output logic signed [COMP_W-1:0] comp  [4]
);

	localparam int M_W = WORK_FRAC + 1;
	localparam int P_W = 2 * M_W;
	localparam logic [P_W-1:0] RND_W = P_W'(1) << (WORK_FRAC - 1);
	localparam logic [V_W:0]   RND_O = (OUT_SHIFT > 0) ? (V_W + 1)'(1) << (OUT_SHIFT - 1) : '0;
	localparam logic [V_W:0]   POS_C = (V_W + 1)'(COMP_POS_MAX);
	localparam logic [V_W:0]   NEG_C = (V_W + 1)'(COMP_NEG_MAX);
	// second products: first-level operand and whether the pitch factor is cosine
	localparam int T_F   [8] = '{0, 1, 2, 3, 1, 0, 2, 3};
	localparam bit T_COS [8] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
	localparam bit C_SUB [4] = '{1'b1, 1'b0, 1'b1, 1'b0};

	logic [M_W-1:0]  sm_s1 [N_AXES];
	logic [M_W-1:0]  cm_s1 [N_AXES];
	logic            sn_s1 [N_AXES];
	logic            cn_s1 [N_AXES];

	logic [P_W-1:0]  fp_s2 [4];
	logic            fn_s2 [4];
	logic [M_W-1:0]  cpm_s2, spm_s2;
	logic            cpn_s2, spn_s2;

	logic [M_W-1:0]  fm_s3 [4];
	logic            fn_s3 [4];
	logic [M_W-1:0]  cpm_s3, spm_s3;
	logic            cpn_s3, spn_s3;

	logic [P_W-1:0]  tp_s4 [8];
	logic            tn_s4 [8];
	logic [M_W-1:0]  tm_s5 [8];
	logic            tn_s5 [8];
	logic signed [V_W-1:0] tv_s6 [8];
	logic signed [V_W:0]   cv_s7 [4];
	logic [V_W-1:0]  cm_s8 [4];
	logic            cn_s8 [4];

	logic [V_W:0]    mr_c [4];
	logic [V_W:0]    mp_c [4];
	logic [V_W:0]    mn_c [4];
	logic signed [COMP_W-1:0] out_c [4];
	logic signed [COMP_W-1:0] comp_s9 [4];

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			mr_c[c]  = ((V_W + 1)'(cm_s8[c]) + RND_O) >> OUT_SHIFT;
			mp_c[c]  = (mr_c[c] > POS_C) ? POS_C : mr_c[c];
			mn_c[c]  = (mr_c[c] > NEG_C) ? NEG_C : mr_c[c];
			out_c[c] = cn_s8[c] ? COMP_W'(-mn_c[c]) : COMP_W'(mp_c[c]);
		end
	end

	always_ff @(posedge clk) begin
		for (int a = 0; a < N_AXES; a++) begin
			sm_s1[a] <= sin_v[a][V_W-1] ? M_W'(-sin_v[a]) : M_W'(sin_v[a]);
			cm_s1[a] <= cos_v[a][V_W-1] ? M_W'(-cos_v[a]) : M_W'(cos_v[a]);
			sn_s1[a] <= sin_v[a][V_W-1];
			cn_s1[a] <= cos_v[a][V_W-1];
		end

		// cy*sr, sy*cr, cy*cr, sy*sr
		fp_s2[0] <= P_W'(cm_s1[AX_YAW]) * P_W'(sm_s1[AX_ROLL]);
		fp_s2[1] <= P_W'(sm_s1[AX_YAW]) * P_W'(cm_s1[AX_ROLL]);
		fp_s2[2] <= P_W'(cm_s1[AX_YAW]) * P_W'(cm_s1[AX_ROLL]);
		fp_s2[3] <= P_W'(sm_s1[AX_YAW]) * P_W'(sm_s1[AX_ROLL]);
		fn_s2[0] <= cn_s1[AX_YAW] ^ sn_s1[AX_ROLL];
		fn_s2[1] <= sn_s1[AX_YAW] ^ cn_s1[AX_ROLL];
		fn_s2[2] <= cn_s1[AX_YAW] ^ cn_s1[AX_ROLL];
		fn_s2[3] <= sn_s1[AX_YAW] ^ sn_s1[AX_ROLL];
		cpm_s2   <= cm_s1[AX_PITCH];
		spm_s2   <= sm_s1[AX_PITCH];
		cpn_s2   <= cn_s1[AX_PITCH];
		spn_s2   <= sn_s1[AX_PITCH];

		for (int i = 0; i < 4; i++) begin
			fm_s3[i] <= M_W'((fp_s2[i] + RND_W) >> WORK_FRAC);
			fn_s3[i] <= fn_s2[i];
		end
		cpm_s3 <= cpm_s2;
		spm_s3 <= spm_s2;
		cpn_s3 <= cpn_s2;
		spn_s3 <= spn_s2;

		for (int i = 0; i < 8; i++) begin
			tp_s4[i] <= P_W'(fm_s3[T_F[i]]) * P_W'(T_COS[i] ? cpm_s3 : spm_s3);
			tn_s4[i] <= fn_s3[T_F[i]] ^ (T_COS[i] ? cpn_s3 : spn_s3);
		end

		for (int i = 0; i < 8; i++) begin
			tm_s5[i] <= M_W'((tp_s4[i] + RND_W) >> WORK_FRAC);
			tn_s5[i] <= tn_s4[i];
			tv_s6[i] <= tn_s5[i] ? -$signed(V_W'(tm_s5[i])) : $signed(V_W'(tm_s5[i]));
		end

		for (int c = 0; c < 4; c++) begin
			cv_s7[c]   <= C_SUB[c] ? (V_W + 1)'(tv_s6[2*c]) - (V_W + 1)'(tv_s6[2*c+1]) :
				(V_W + 1)'(tv_s6[2*c]) + (V_W + 1)'(tv_s6[2*c+1]);
			cm_s8[c]   <= cv_s7[c][V_W] ? V_W'(-cv_s7[c]) : V_W'(cv_s7[c]);
			cn_s8[c]   <= cv_s7[c][V_W];
			comp_s9[c] <= out_c[c];
		end
	end

	assign comp = comp_s9;

endmodule

// ===== hdl/euler_to_quaternion.sv =====
// channel   signals                                   direction  transfer
// request   start, busy, roll/pitch/yaw_angle          in         start & !busy
// result    done, quat_x, quat_y, quat_z, quat_w       out        done, one cycle
//
// one request per cycle while busy is low
// pipeline: range reduction, the six-cell taylor chain, quadrant mapping, products
// busy is high in reset and for the first cycle after it, low otherwise
// arst_n clears the valid pipeline; payload registers are not reset
// the receiver cannot stall, so no flow control on the result side
module euler_to_quaternion import e2q_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic signed [ANGLE_W-1:0] roll_angle,
	input  logic signed [ANGLE_W-1:0] pitch_angle,
	input  logic signed [ANGLE_W-1:0] yaw_angle,
	output logic                      done,
	output logic signed [COMP_W-1:0]  quat_x,
	output logic signed [COMP_W-1:0]  quat_y,
	output logic signed [COMP_W-1:0]  quat_z,
	output logic signed [COMP_W-1:0]  quat_w
);

	logic                     busy_q;
	logic [TOTAL_LAT-1:0]     vld_q;
	logic signed [ANGLE_W-1:0] ang   [N_AXES];
	logic signed [V_W-1:0]    sin_v [N_AXES];
	logic signed [V_W-1:0]    cos_v [N_AXES];
	logic signed [COMP_W-1:0] comp  [4];

	assign ang[AX_ROLL]  = roll_angle;
	assign ang[AX_PITCH] = pitch_angle;
	assign ang[AX_YAW]   = yaw_angle;

	genvar g;
	for (g = 0; g < N_AXES; g++) begin : g_axis
		e2q_sincos u_sincos (
			.clk   (clk),
			.angle (ang[g]),
			.sin_v (sin_v[g]),
			.cos_v (cos_v[g])
		);
	end

	e2q_combine u_combine (
		.clk   (clk),
		.sin_v (sin_v),
		.cos_v (cos_v),
		.comp  (comp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			vld_q  <= '0;
		end else begin
			busy_q <= 1'b0;
			vld_q  <= {vld_q[TOTAL_LAT-2:0], start & ~busy_q};
		end
	end

	assign busy   = busy_q;
	assign done   = vld_q[TOTAL_LAT-1];
	assign quat_x = comp[0];
	assign quat_y = comp[1];
	assign quat_z = comp[2];
	assign quat_w = comp[3];

endmodule

// ===== hdl/e2q_checker.sv =====
module e2q_checker import e2q_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input logic signed [ANGLE_W-1:0] roll_angle,
	input logic signed [ANGLE_W-1:0] pitch_angle,
	input logic signed [ANGLE_W-1:0] yaw_angle,
	input logic                      done,
	input logic signed [COMP_W-1:0]  quat_x,
	input logic signed [COMP_W-1:0]  quat_y,
	input logic signed [COMP_W-1:0]  quat_z,
	input logic signed [COMP_W-1:0]  quat_w
);

	// no result without a request a fixed latency earlier
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, TOTAL_LAT))
		else $error("result without matching request");

	// every request yields a result after the fixed latency
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##TOTAL_LAT done)
		else $error("request lost");

	// busy only right after reset
	a_busy_short: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("busy held outside reset");

	// components stay within plus or minus one
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (quat_x <= COMP_POS_MAX && quat_x >= -COMP_NEG_MAX &&
			quat_y <= COMP_POS_MAX && quat_y >= -COMP_NEG_MAX &&
			quat_z <= COMP_POS_MAX && quat_z >= -COMP_NEG_MAX &&
			quat_w <= COMP_POS_MAX && quat_w >= -COMP_NEG_MAX))
		else $error("component out of range");

	// zero angles give the identity rotation
	a_identity: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && roll_angle == '0 && pitch_angle == '0 && yaw_angle == '0)
		|-> ##TOTAL_LAT (quat_x == '0 && quat_y == '0 && quat_z == '0 &&
			quat_w == COMP_W'(COMP_POS_MAX)))
		else $error("identity rotation wrong");

endmodule

bind euler_to_quaternion e2q_checker u_chk (.*);

// ===== verif/tb_euler_to_quaternion.sv =====
`timescale 1ns / 1ps

module tb_euler_to_quaternion;
	import e2q_pkg::*;

	localparam int        Q_FRAC         = 30;
	localparam int        ROUND_SH       = Q_FRAC - COMPONENT_FRAC_BITS;
	localparam bit [63:0] HALF_PI_Q30    = 64'h6487ED51;
	localparam bit [63:0] QUARTER_PI_Q30 = 64'h3243F6A9;
	localparam int        IDLE_LIMIT     = 1000;
	localparam int        N_RANDOM       = 1700;
	localparam int        N_DIRECTED     = 20;

	typedef struct packed {
		logic signed [COMP_W-1:0] x;
		logic signed [COMP_W-1:0] y;
		logic signed [COMP_W-1:0] z;
		logic signed [COMP_W-1:0] w;
	} quat_t;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] roll;
		logic signed [ANGLE_W-1:0] pitch;
		logic signed [ANGLE_W-1:0] yaw;
		logic                      fixed_want;
		quat_t                     want;
	} euler_row_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic signed [ANGLE_W-1:0] roll_angle;
	logic signed [ANGLE_W-1:0] pitch_angle;
	logic signed [ANGLE_W-1:0] yaw_angle;
	logic                      done;
	logic signed [COMP_W-1:0]  quat_x;
	logic signed [COMP_W-1:0]  quat_y;
	logic signed [COMP_W-1:0]  quat_z;
	logic signed [COMP_W-1:0]  quat_w;

	quat_t expected_quats[$];
	quat_t head_quat;
	int    errors      = 0;
	int    idle_cycles = 0;

	// pi/2 = 6434, pi = 12868 in Q4.12; odd multiples of pi/2 sit on quadrant edges
	euler_row_t dir_rows [N_DIRECTED] = '{
		'{0, 0, 0, 1'b1, '{0, 0, 0, 16384}},
		'{32767, 0, 0, 1'b0, '0},
		'{-32768, 0, 0, 1'b0, '0},
		'{0, 32767, 0, 1'b0, '0},
		'{0, -32768, 0, 1'b0, '0},
		'{0, 0, 32767, 1'b0, '0},
		'{0, 0, -32768, 1'b0, '0},
		'{32767, 32767, 32767, 1'b0, '0},
		'{-32768, -32768, -32768, 1'b0, '0},
		'{1, -1, 1, 1'b0, '0},
		'{6434, 0, 0, 1'b0, '0},
		'{0, 6434, 0, 1'b0, '0},
		'{0, -6434, 0, 1'b0, '0},
		'{12868, 12868, 12868, 1'b0, '0},
		'{-12868, 0, 12868, 1'b0, '0},
		'{25736, -25736, 25736, 1'b0, '0},
		'{19302, 6433, -19302, 1'b0, '0},
		'{6433, 6435, 32170, 1'b0, '0},
		'{21845, -21846, 21845, 1'b0, '0},
		'{-21846, 21845, -21846, 1'b0, '0}
	};

	euler_to_quaternion dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.roll_angle (roll_angle),
		.pitch_angle(pitch_angle),
		.yaw_angle  (yaw_angle),
		.done       (done),
		.quat_x     (quat_x),
		.quat_y     (quat_y),
		.quat_z     (quat_z),
		.quat_w     (quat_w)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// sine and cosine of half the angle, Q2.30
	function automatic void half_angle_trig(input longint angle, output longint s,
		output longint c);
		longint      h;
		longint      r;
		longint      sr;
		longint      cr;
		logic [63:0] x;
		logic [63:0] k;
		logic [63:0] ra;
		logic [63:0] r2;
		logic [63:0] term;
		h = angle * (longint'(1) << (Q_FRAC - 1 - ANGLE_FRAC_BITS));
		x = (h < 0) ? -h : h;
		k = (x + QUARTER_PI_Q30) / HALF_PI_Q30;
		r = longint'(x) - longint'(k * HALF_PI_Q30);
		ra = (r < 0) ? -r : r;
		r2 = (ra * ra) >> Q_FRAC;
		sr = 0;
		cr = 0;
		term = ra;
		for (int n = 1; n <= 13; n += 2) begin
			sr = (n & 2) ? sr - longint'(term) : sr + longint'(term);
			term = ((term * r2) >> Q_FRAC) / 64'((n + 1) * (n + 2));
		end
		term = 64'd1 << Q_FRAC;
		for (int n = 0; n <= 12; n += 2) begin
			cr = (n & 2) ? cr - longint'(term) : cr + longint'(term);
			term = ((term * r2) >> Q_FRAC) / 64'((n + 1) * (n + 2));
		end
		if (r < 0)
			sr = -sr;
		case (k[1:0])
			2'd0: begin
				s = sr;
				c = cr;
			end
			2'd1: begin
				s = cr;
				c = -sr;
			end
			2'd2: begin
				s = -sr;
				c = -cr;
			end
			default: begin
				s = -cr;
				c = sr;
			end
		endcase
		if (h < 0)
			s = -s;
	endfunction

	// Q2.30 product, rounded half away from zero
	function automatic longint mul_q30(input longint a, input longint b);
		logic [63:0] ma;
		logic [63:0] mb;
		logic [63:0] m;
		ma = (a < 0) ? -a : a;
		mb = (b < 0) ? -b : b;
		m = (ma * mb + (64'd1 << (Q_FRAC - 1))) >> Q_FRAC;
		return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
	endfunction

	function automatic logic signed [COMP_W-1:0] to_component(input longint v);
		logic [63:0] m;
		longint      q;
		m = (v < 0) ? -v : v;
		m = (m + (64'd1 << (ROUND_SH - 1))) >> ROUND_SH;
		if (m > (64'd1 << COMPONENT_FRAC_BITS))
			m = 64'd1 << COMPONENT_FRAC_BITS;
		q = (v < 0) ? -longint'(m) : longint'(m);
		if (q > 32767)
			q = 32767;
		if (q < -32768)
			q = -32768;
		return q[COMP_W-1:0];
	endfunction

	function automatic quat_t euler_quat(input logic signed [ANGLE_W-1:0] roll,
		input logic signed [ANGLE_W-1:0] pitch, input logic signed [ANGLE_W-1:0] yaw);
		longint sr, cr, sp, cp, sy, cy;
		quat_t  q;
		half_angle_trig(longint'(roll), sr, cr);
		half_angle_trig(longint'(pitch), sp, cp);
		half_angle_trig(longint'(yaw), sy, cy);
		q.x = to_component(mul_q30(mul_q30(cy, sr), cp) - mul_q30(mul_q30(sy, cr), sp));
		q.y = to_component(mul_q30(mul_q30(cy, cr), sp) + mul_q30(mul_q30(sy, sr), cp));
		q.z = to_component(mul_q30(mul_q30(sy, cr), cp) - mul_q30(mul_q30(cy, sr), sp));
		q.w = to_component(mul_q30(mul_q30(cy, cr), cp) + mul_q30(mul_q30(sy, sr), sp));
		return q;
	endfunction

	function automatic logic signed [ANGLE_W-1:0] rand_angle();
		int odd;
		case ($urandom_range(0, 9))
			5: return ANGLE_W'($urandom_range(0, 1024) - 512);
			6: begin
				odd = 2 * $urandom_range(0, 5) - 5;
				return ANGLE_W'(odd * 6434 + $urandom_range(0, 6) - 3);
			end
			7: begin
				case ($urandom_range(0, 4))
					0: return 32767;
					1: return -32768;
					2: return 1;
					3: return -1;
					default: return 0;
				endcase
			end
			default: return ANGLE_W'($urandom());
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		errors++;
	endtask

	// called at a falling edge, returns at the falling edge after the request is taken
	task automatic send_request(input logic signed [ANGLE_W-1:0] roll,
		input logic signed [ANGLE_W-1:0] pitch, input logic signed [ANGLE_W-1:0] yaw,
		input quat_t want, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		roll_angle <= roll;
		pitch_angle <= pitch;
		yaw_angle <= yaw;
		do @(posedge clk); while (busy);
		expected_quats.push_back(want);
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		if (done) begin
			if (expected_quats.size() == 0) begin
				report_mismatch($sformatf("result with no request pending: %0d %0d %0d %0d",
					quat_x, quat_y, quat_z, quat_w));
			end else begin
				head_quat = expected_quats.pop_front();
				if (quat_x !== head_quat.x)
					report_mismatch($sformatf("quat_x got %0d expected %0d", quat_x, head_quat.x));
				if (quat_y !== head_quat.y)
					report_mismatch($sformatf("quat_y got %0d expected %0d", quat_y, head_quat.y));
				if (quat_z !== head_quat.z)
					report_mismatch($sformatf("quat_z got %0d expected %0d", quat_z, head_quat.z));
				if (quat_w !== head_quat.w)
					report_mismatch($sformatf("quat_w got %0d expected %0d", quat_w, head_quat.w));
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int                        burst_left;
		bit                        no_gaps;
		logic signed [ANGLE_W-1:0] roll;
		logic signed [ANGLE_W-1:0] pitch;
		logic signed [ANGLE_W-1:0] yaw;
		arst_n = 1'b0;
		start = 1'b0;
		roll_angle = '0;
		pitch_angle = '0;
		yaw_angle = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			send_request(dir_rows[i].roll, dir_rows[i].pitch, dir_rows[i].yaw,
				dir_rows[i].fixed_want ? dir_rows[i].want :
				euler_quat(dir_rows[i].roll, dir_rows[i].pitch, dir_rows[i].yaw),
				$urandom_range(0, 15));
		end

		// mix back-to-back bursts with randomly spaced requests
		burst_left = 0;
		no_gaps = 1'b0;
		for (int i = 0; i < N_RANDOM; i++) begin
			if (burst_left == 0) begin
				no_gaps = ($urandom_range(0, 3) == 0);
				burst_left = $urandom_range(10, 60);
			end
			burst_left--;
			roll = rand_angle();
			pitch = rand_angle();
			yaw = rand_angle();
			send_request(roll, pitch, yaw, euler_quat(roll, pitch, yaw),
				no_gaps ? 0 : $urandom_range(0, 15));
		end
		start <= 1'b0;

		while (expected_quats.size() != 0)
			@(posedge clk);
		repeat (TOTAL_LAT + 8) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/e2q_pkg.sv
hdl/e2q_reduce.sv
hdl/e2q_cell.sv
hdl/e2q_sincos.sv
hdl/e2q_combine.sv
hdl/euler_to_quaternion.sv
hdl/e2q_checker.sv
verif/tb_euler_to_quaternion.sv
